// File: design/vkmt_pkg.sv
`timescale 1ns / 1ps

package vkmt_pkg;

  // Table geometry.
  localparam int GROUPS     = 16;
  localparam int ENTRIES    = 128;
  localparam int KEY_LEN    = 8;
  localparam int ELEM_WIDTH = 16;

  // Fixed request field widths.
  localparam int KEY_IN_W   = 16;
  localparam int GROUP_IN_W = 4;
  localparam int KCOUNT_W   = 4;
  localparam int VALUE_W    = 64;
  localparam int MAX_KEYS   = 8;

  // Derived widths.
  localparam int GROUP_W    = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int CNT_W      = $clog2(ENTRIES + 1);
  localparam int ROWS       = GROUPS * ENTRIES;
  localparam int ROW_W      = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int KEY_ROW_W  = KEY_LEN * ELEM_WIDTH;
  localparam int DATA_W     = VALUE_W + KEY_ROW_W;

  // Request codes.
  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_STORE  = 1'b1;

  // Response status codes.
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic                        req_type;
    logic [GROUP_IN_W-1:0]       group;
    logic [KCOUNT_W-1:0]         key_count;
    logic signed [KEY_IN_W-1:0]  key_0;
    logic signed [KEY_IN_W-1:0]  key_1;
    logic signed [KEY_IN_W-1:0]  key_2;
    logic signed [KEY_IN_W-1:0]  key_3;
    logic signed [KEY_IN_W-1:0]  key_4;
    logic signed [KEY_IN_W-1:0]  key_5;
    logic signed [KEY_IN_W-1:0]  key_6;
    logic signed [KEY_IN_W-1:0]  key_7;
    logic [VALUE_W-1:0]          store_value;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic [VALUE_W-1:0] found_value;
    logic               status;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture a new request
    logic write;     // append the request to its partition
    logic set_full;  // record a refused store
    logic search;    // issue entry reads for a lookup
    logic set_hit;   // capture the value of the matching entry
    logic emit;      // move the result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_store;
    logic full;
    logic empty;
    logic match;
    logic last;
    logic out_free;
  } stat_t;

  // Sign-extend a key element and keep its low ELEM_WIDTH bits.
  function automatic logic [ELEM_WIDTH-1:0] norm_elem(input logic signed [KEY_IN_W-1:0] raw);
    logic signed [31:0] ext;
    ext = 32'(raw);
    return ext[ELEM_WIDTH-1:0];
  endfunction

  // Partition index: the group number folded into the partition count.
  function automatic logic [GROUP_W-1:0] group_index(input logic [GROUP_IN_W-1:0] grp);
    logic [GROUP_W-1:0] idx;
    idx = '0;
    for (int k = 0; k < (1 << GROUP_IN_W); k++) begin
      if (grp == GROUP_IN_W'(k)) begin
        idx = GROUP_W'(k % GROUPS);
      end
    end
    return idx;
  endfunction

endpackage

// File: design/vkmt_ctrl.sv
`timescale 1ns / 1ps

module vkmt_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  vkmt_pkg::stat_t stat,
  output vkmt_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_DECIDE = 4'b0010,
    S_SEARCH = 4'b0100,
    S_DONE   = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // A new request is taken only while no request is in progress.
  assign req_stall = (state != S_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.is_store) begin
          if (stat.full) begin
            cmd.set_full = 1'b1;
          end else begin
            cmd.write = 1'b1;
          end
          state_next = S_DONE;
        end else if (stat.empty) begin
          state_next = S_DONE;
        end else begin
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        cmd.search = 1'b1;
        if (stat.match) begin
          cmd.set_hit = 1'b1;
          state_next  = S_DONE;
        end else if (stat.last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: design/vkmt_datapath.sv
`timescale 1ns / 1ps

module vkmt_datapath (
  input  logic            clk,
  input  logic            rst,
  input  vkmt_pkg::req_t  req,
  input  vkmt_pkg::cmd_t  cmd,
  output vkmt_pkg::stat_t stat,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output vkmt_pkg::rsp_t  rsp
);

  // Captured request.
  logic                                               cur_type;
  logic [vkmt_pkg::GROUP_W-1:0]                       cur_group;
  logic [vkmt_pkg::KCOUNT_W-1:0]                      cur_n;
  logic [vkmt_pkg::KEY_LEN-1:0][vkmt_pkg::ELEM_WIDTH-1:0] cur_key;
  logic [vkmt_pkg::VALUE_W-1:0]                       cur_value;
  logic [vkmt_pkg::ROW_W-1:0]                         cur_base;

  // Per-partition fill counts.
  logic [vkmt_pkg::CNT_W-1:0] entry_count [vkmt_pkg::GROUPS];
  logic [vkmt_pkg::CNT_W-1:0] cur_cnt;

  // Entry memory: one row holds a value and all key elements.
  logic [vkmt_pkg::DATA_W-1:0] mem [vkmt_pkg::ROWS];
  logic [vkmt_pkg::DATA_W-1:0] mem_q;
  logic [vkmt_pkg::ROW_W-1:0]  rd_addr;
  logic [vkmt_pkg::ROW_W-1:0]  wr_addr;
  logic                        rd_en;

  // Search pointers.
  logic [vkmt_pkg::CNT_W-1:0] rd_idx;
  logic [vkmt_pkg::CNT_W-1:0] cmp_idx;
  logic                       cmp_valid;

  // Result being built.
  logic                         res_hit;
  logic [vkmt_pkg::VALUE_W-1:0] res_value;
  logic                         res_status;

  logic signed [vkmt_pkg::KEY_IN_W-1:0] key_in [vkmt_pkg::MAX_KEYS];
  logic [vkmt_pkg::GROUP_W-1:0]         in_group;
  logic [vkmt_pkg::KCOUNT_W-1:0]        in_n;
  logic [vkmt_pkg::KEY_LEN-1:0]         elem_eq;
  logic [vkmt_pkg::KEY_ROW_W-1:0]       row_key;
  logic [vkmt_pkg::VALUE_W-1:0]         row_value;

  assign key_in[0] = req.key_0;
  assign key_in[1] = req.key_1;
  assign key_in[2] = req.key_2;
  assign key_in[3] = req.key_3;
  assign key_in[4] = req.key_4;
  assign key_in[5] = req.key_5;
  assign key_in[6] = req.key_6;
  assign key_in[7] = req.key_7;

  assign in_group = vkmt_pkg::group_index(req.group);
  assign in_n     = (req.key_count > vkmt_pkg::KCOUNT_W'(vkmt_pkg::KEY_LEN)) ?
                    vkmt_pkg::KCOUNT_W'(vkmt_pkg::KEY_LEN) : req.key_count;

  // Capture the request on acceptance.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_type  <= req.req_type;
      cur_group <= in_group;
      cur_n     <= in_n;
      cur_value <= req.store_value;
      cur_base  <= vkmt_pkg::ROW_W'(int'(in_group) * vkmt_pkg::ENTRIES);
      for (int i = 0; i < vkmt_pkg::KEY_LEN; i++) begin
        cur_key[i] <= vkmt_pkg::norm_elem(key_in[i]);
      end
    end
  end

  assign cur_cnt = entry_count[cur_group];

  // Fill counts clear at reset and grow by one on each accepted store.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int g = 0; g < vkmt_pkg::GROUPS; g++) begin
        entry_count[g] <= '0;
      end
    end else if (cmd.write) begin
      entry_count[cur_group] <= cur_cnt + vkmt_pkg::CNT_W'(1);
    end
  end

  // Memory addressing: stores append at the fill count, lookups walk from the oldest entry.
  assign wr_addr = cur_base + vkmt_pkg::ROW_W'(cur_cnt);
  assign rd_addr = cur_base + vkmt_pkg::ROW_W'(rd_idx);
  assign rd_en   = cmd.search && (rd_idx < cur_cnt);

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      mem[wr_addr] <= {cur_value, cur_key};
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  // Read pointer and the compare stage that follows the memory read.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx    <= '0;
      cmp_idx   <= '0;
      cmp_valid <= 1'b0;
    end else begin
      cmp_valid <= rd_en;
      if (cmd.load) begin
        rd_idx <= '0;
      end else if (rd_en) begin
        rd_idx  <= rd_idx + vkmt_pkg::CNT_W'(1);
        cmp_idx <= rd_idx;
      end
    end
  end

  assign row_key   = mem_q[vkmt_pkg::KEY_ROW_W-1:0];
  assign row_value = mem_q[vkmt_pkg::DATA_W-1:vkmt_pkg::KEY_ROW_W];

  // Element compare; elements past the requested count always agree.
  always_comb begin
    for (int i = 0; i < vkmt_pkg::KEY_LEN; i++) begin
      elem_eq[i] = (int'(cur_n) <= i) ||
                   (row_key[i*vkmt_pkg::ELEM_WIDTH +: vkmt_pkg::ELEM_WIDTH] == cur_key[i]);
    end
  end

  // Status toward the controller.
  always_comb begin
    stat.is_store = (cur_type == vkmt_pkg::REQ_STORE);
    stat.full     = (cur_cnt == vkmt_pkg::CNT_W'(vkmt_pkg::ENTRIES));
    stat.empty    = (cur_cnt == '0);
    stat.match    = cmp_valid && (&elem_eq);
    stat.last     = cmp_valid && ((cmp_idx + vkmt_pkg::CNT_W'(1)) == cur_cnt);
    stat.out_free = !rsp_valid || !rsp_stall;
  end

  // Result fields, reset on acceptance.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_hit    <= 1'b0;
      res_value  <= '0;
      res_status <= vkmt_pkg::STATUS_OK;
    end else begin
      if (cmd.set_full) begin
        res_status <= vkmt_pkg::STATUS_FULL;
      end
      if (cmd.set_hit) begin
        res_hit   <= 1'b1;
        res_value <= row_value;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.emit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      rsp.hit         <= res_hit;
      rsp.found_value <= res_value;
      rsp.status      <= res_status;
    end
  end

endmodule

// File: design/vector_key_memo_table.sv
`timescale 1ns / 1ps

// Partitioned memo table with linear search. Each request names a partition;
// a store appends its key vector and 64-bit value to that partition, or
// answers with a full status when the partition already holds its maximum
// number of entries; a lookup returns the value of the oldest entry whose
// leading key_count elements match the request, or a miss with a zero value.
// Entries live in one single-port memory, one row per entry with the value
// and all key elements side by side, so a lookup reads one stored entry per
// cycle and compares all elements of that entry at once. A store passes
// through the idle, decide and done states, and so does a lookup on an empty
// partition; any other lookup also passes through the search state, which
// examines at most ENTRIES entries, oldest first. A stalled output holds
// the done state until the output register is free. One request is
// processed at a time; a finished response waits in the output register
// while the next request is accepted. No clearing pass follows reset: only
// the fill counts are cleared, and entries are read only after written.
module vector_key_memo_table (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  vkmt_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output vkmt_pkg::rsp_t rsp
);

  vkmt_pkg::cmd_t  cmd;
  vkmt_pkg::stat_t stat;

  // Sequencing of each request.
  vkmt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Storage, compare and response register.
  vkmt_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

// File: tb/vkmt_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the memo table. It keeps its own copy of every
// partition and checks each response against the answer predicted for the
// oldest open request.
module vkmt_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic           req_stall,
  input  vkmt_pkg::req_t req,
  input  logic           rsp_valid,
  input  logic           rsp_stall,
  input  vkmt_pkg::rsp_t rsp,
  output int             fail_count,
  output int             open_count
);

  import vkmt_pkg::*;

  // Shadow copy of the table contents.
  int                    fill      [GROUPS];
  logic [ELEM_WIDTH-1:0] key_mem   [GROUPS][ENTRIES][KEY_LEN];
  logic [VALUE_W-1:0]    value_mem [GROUPS][ENTRIES];

  // Answers still owed by the block, oldest first.
  rsp_t answer_q[$];

  // Applies one request to the shadow table and returns the answer it earns.
  function automatic rsp_t memo_answer(req_t r);
    rsp_t                           a;
    int                             g;
    int                             n;
    logic [MAX_KEYS*KEY_IN_W-1:0]   kv;
    logic signed [31:0]             ext;
    logic [ELEM_WIDTH-1:0]          ke [KEY_LEN];
    logic                           same;
    a  = '0;
    g  = int'(r.group) % GROUPS;
    n  = (int'(r.key_count) > KEY_LEN) ? KEY_LEN : int'(r.key_count);
    kv = {r.key_7, r.key_6, r.key_5, r.key_4, r.key_3, r.key_2, r.key_1, r.key_0};
    // Each element is sign-extended, then cut to the stored width.
    for (int i = 0; i < KEY_LEN; i++) begin
      ext   = 32'(signed'(kv[i*KEY_IN_W +: KEY_IN_W]));
      ke[i] = ext[ELEM_WIDTH-1:0];
    end
    if (r.req_type == REQ_STORE) begin
      // A store appends the whole key, or is refused on a full partition.
      if (fill[g] < ENTRIES) begin
        for (int i = 0; i < KEY_LEN; i++) key_mem[g][fill[g]][i] = ke[i];
        value_mem[g][fill[g]] = r.store_value;
        fill[g]++;
      end else begin
        a.status = STATUS_FULL;
      end
    end else begin
      // A lookup takes the oldest entry whose leading elements all agree.
      for (int e = 0; e < fill[g]; e++) begin
        same = 1'b1;
        for (int i = 0; i < n; i++) begin
          if (key_mem[g][e][i] != ke[i]) same = 1'b0;
        end
        if (same && !a.hit) begin
          a.hit         = 1'b1;
          a.found_value = value_mem[g][e];
        end
      end
    end
    return a;
  endfunction

  // Compare responses first, then record the request taken at the same edge.
  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      foreach (fill[g]) fill[g] = 0;
      answer_q.delete();
      fail_count = 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (answer_q.size() == 0) begin
          $error("response with no open request: hit %0d found_value %h status %0d",
                 rsp.hit, rsp.found_value, rsp.status);
          fail_count++;
        end else begin
          want = answer_q.pop_front();
          if (rsp.hit !== want.hit) begin
            $error("hit: expected %0d, actual %0d", want.hit, rsp.hit);
            fail_count++;
          end
          if (rsp.found_value !== want.found_value) begin
            $error("found_value: expected %h, actual %h", want.found_value, rsp.found_value);
            fail_count++;
          end
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, rsp.status);
            fail_count++;
          end
        end
      end
      if (req_valid && !req_stall) answer_q.push_back(memo_answer(req));
    end
    open_count = answer_q.size();
  end

endmodule

// File: tb/vector_key_memo_table_tb.sv
`timescale 1ns / 1ps

module vector_key_memo_table_tb;

  import vkmt_pkg::*;

  typedef logic [MAX_KEYS*KEY_IN_W-1:0] keyvec_t;

  localparam int      RANDOM_ITEMS = 1926;
  localparam keyvec_t KEY_MIX      = 128'h0001_ffff_8000_7fff_0000_1234_edcb_5555;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  int fail_count;
  int open_count;
  int gap_pct   = 0;
  int stall_pct = 0;

  // Keys and partitions of every store issued, reused to aim lookups at hits.
  int      stored_group[$];
  keyvec_t stored_key[$];

  vector_key_memo_table u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  vkmt_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp),
    .fail_count (fail_count),
    .open_count (open_count)
  );

  always #5 clk = ~clk;

  // Response back-pressure at the rate of the current phase.
  always @(posedge clk) begin
    rsp_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  function automatic req_t make_req(logic t, int g, int n, keyvec_t k, logic [VALUE_W-1:0] v);
    req_t r;
    r.req_type    = t;
    r.group       = GROUP_IN_W'(g);
    r.key_count   = KCOUNT_W'(n);
    r.key_0       = k[0*KEY_IN_W +: KEY_IN_W];
    r.key_1       = k[1*KEY_IN_W +: KEY_IN_W];
    r.key_2       = k[2*KEY_IN_W +: KEY_IN_W];
    r.key_3       = k[3*KEY_IN_W +: KEY_IN_W];
    r.key_4       = k[4*KEY_IN_W +: KEY_IN_W];
    r.key_5       = k[5*KEY_IN_W +: KEY_IN_W];
    r.key_6       = k[6*KEY_IN_W +: KEY_IN_W];
    r.key_7       = k[7*KEY_IN_W +: KEY_IN_W];
    r.store_value = v;
    return r;
  endfunction

  // Key elements lean toward the extremes and a few small values so that
  // stored keys share prefixes.
  function automatic logic [KEY_IN_W-1:0] key_elem();
    logic [KEY_IN_W-1:0] e;
    case ($urandom_range(0, 7))
      0:       e = 16'h8000;
      1:       e = 16'h7fff;
      2:       e = 16'hffff;
      3:       e = 16'h0000;
      4:       e = 16'h0001;
      default: e = KEY_IN_W'($urandom());
    endcase
    return e;
  endfunction

  function automatic keyvec_t random_key();
    keyvec_t k;
    for (int i = 0; i < MAX_KEYS; i++) k[i*KEY_IN_W +: KEY_IN_W] = key_elem();
    return k;
  endfunction

  // Offers one request after a random gap and holds it until it is taken.
  task automatic send(req_t r);
    while ($urandom_range(0, 99) < gap_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  initial begin
    keyvec_t k;
    int      g;
    int      n;
    int      pick;
    int      j;
    logic    t;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Lookups on an empty partition miss, even with nothing to compare.
    send(make_req(REQ_LOOKUP, 0, 8, '0, '0));
    send(make_req(REQ_LOOKUP, 0, 0, '0, '0));
    // Fill partition 0 with extreme keys and a duplicate of one mixed key.
    send(make_req(REQ_STORE, 0, 8, {MAX_KEYS{16'h8000}}, '1));
    send(make_req(REQ_STORE, 0, 0, {MAX_KEYS{16'h7fff}}, '0));
    send(make_req(REQ_STORE, 0, 15, KEY_MIX, 64'h3ff0_0000_0000_0000));
    send(make_req(REQ_STORE, 0, 3, KEY_MIX, 64'h4000_0000_0000_0000));
    // Zero count matches the oldest entry; a count above the key length saturates.
    send(make_req(REQ_LOOKUP, 0, 0, KEY_MIX, '0));
    send(make_req(REQ_LOOKUP, 0, 8, {MAX_KEYS{16'h7fff}}, '0));
    send(make_req(REQ_LOOKUP, 0, 15, KEY_MIX, '0));
    // The duplicate stays hidden behind the earlier entry.
    send(make_req(REQ_LOOKUP, 0, 8, KEY_MIX, '0));
    // Only the leading elements take part in the compare.
    send(make_req(REQ_LOOKUP, 0, 1, {{7{16'h2222}}, 16'h5555}, '0));
    send(make_req(REQ_LOOKUP, 0, 7, KEY_MIX ^ {16'h0100, 112'h0}, '0));
    send(make_req(REQ_LOOKUP, 0, 8, KEY_MIX ^ {16'h0100, 112'h0}, '0));
    // Partitions are separate.
    send(make_req(REQ_LOOKUP, 1, 8, KEY_MIX, '0));
    send(make_req(REQ_STORE, 15, 8, {MAX_KEYS{16'h8000}}, 64'h8000_0000_0000_0001));
    send(make_req(REQ_LOOKUP, 15, 2, {{6{16'h1357}}, {2{16'h8000}}}, '0));
    send(make_req(REQ_LOOKUP, 15, 9, {MAX_KEYS{16'h8000}}, '0));
    send(make_req(REQ_LOOKUP, 14, 0, {MAX_KEYS{16'h8000}}, '0));

    // Random traffic in three idling phases. Stores crowd into a few
    // partitions so that those fill up and refuse further stores.
    for (int ph = 0; ph < 3; ph++) begin
      gap_pct   = (ph == 0) ? 17 : (ph == 1) ? 81 : 0;
      stall_pct <= (ph == 0) ? 81 : (ph == 1) ? 17 : 0;
      repeat (RANDOM_ITEMS / 3) begin
        n    = $urandom_range(0, 15);
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          t = REQ_STORE;
          g = ($urandom_range(0, 99) < 70) ? $urandom_range(0, 3) : $urandom_range(0, 15);
          k = random_key();
          if (stored_key.size() > 0 && $urandom_range(0, 4) == 0) begin
            // An earlier key with one element changed.
            k = stored_key[$urandom_range(0, stored_key.size() - 1)];
            j = $urandom_range(0, MAX_KEYS - 1);
            k[j*KEY_IN_W +: KEY_IN_W] = key_elem();
          end
          stored_group.push_back(g);
          stored_key.push_back(k);
        end else if (pick < 85 && stored_key.size() > 0) begin
          // Look up a stored key, sometimes disturbed in one element or partition.
          t = REQ_LOOKUP;
          j = $urandom_range(0, stored_key.size() - 1);
          g = stored_group[j];
          k = stored_key[j];
          if ($urandom_range(0, 9) < 3) begin
            j = $urandom_range(0, MAX_KEYS - 1);
            k[j*KEY_IN_W +: KEY_IN_W] = key_elem();
          end
          if ($urandom_range(0, 9) == 0) g = $urandom_range(0, 15);
        end else begin
          t = REQ_LOOKUP;
          g = $urandom_range(0, 15);
          k = random_key();
        end
        send(make_req(t, g, n, k, {$urandom(), $urandom()}));
      end
    end
    req_valid <= 1'b0;

    // Drain, then watch a little longer for stray responses.
    while (open_count != 0) @(posedge clk);
    repeat (ENTRIES + 16) @(posedge clk);
    if (fail_count == 0) begin
      $display("[vector_key_memo_table] OK");
    end else begin
      $display("[vector_key_memo_table] ERROR");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #20ms;
    $display("[vector_key_memo_table] ERROR");
    $finish;
  end

endmodule

// File: vector_key_memo_table.f
design/vkmt_pkg.sv
design/vkmt_ctrl.sv
design/vkmt_datapath.sv
design/vector_key_memo_table.sv
tb/vkmt_checker.sv
tb/vector_key_memo_table_tb.sv
